/* design/pidt_pkg.sv */
// Shared widths, operation codes, register indexes and types of the PID controller.
package pidt_pkg;

    // Field widths of the sample and result words, the gains and the integrator.
    localparam int SAMPLE_W   = 16;
    localparam int ELAPSED_W  = 16;
    localparam int GAIN_W     = 16;
    localparam int DRIVE_W    = 16;
    localparam int INTEG_W    = 48;
    localparam int INTEG_FRAC = 17;

    // Derived datapath widths.
    localparam int ERR_W     = SAMPLE_W + 1;
    localparam int ESUM_W    = SAMPLE_W + 2;
    localparam int INC_W     = ESUM_W + ELAPSED_W;
    localparam int IPART_W   = INTEG_W / 2;
    localparam int MUL_A_W   = IPART_W + 1;
    localparam int MUL_B_W   = GAIN_W + 1;
    localparam int PROD_W    = MUL_A_W + MUL_B_W;
    localparam int IACC_W    = INTEG_W + GAIN_W;
    localparam int ACC_W     = 52;
    localparam int QUO_W     = SAMPLE_W + ELAPSED_W;
    localparam int SLOPE_W   = QUO_W + 1;
    localparam int SLO_W     = 17;
    localparam int IN_DATA_W = 2 * SAMPLE_W + ELAPSED_W;

    // Configuration port.
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_PROP  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_INTEG = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_DERIV = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_OUT_UPPER  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_OUT_LOWER  = 3'd4;

    // Datapath operation codes.
    localparam int OP_W = 5;
    localparam logic [OP_W-1:0] OP_NONE     = 5'd0;
    localparam logic [OP_W-1:0] OP_LOAD     = 5'd1;
    localparam logic [OP_W-1:0] OP_MUL_INC  = 5'd2;
    localparam logic [OP_W-1:0] OP_ACC_INT  = 5'd3;
    localparam logic [OP_W-1:0] OP_MUL_P    = 5'd4;
    localparam logic [OP_W-1:0] OP_ADD_P    = 5'd5;
    localparam logic [OP_W-1:0] OP_MUL_IL   = 5'd6;
    localparam logic [OP_W-1:0] OP_ADD_IL   = 5'd7;
    localparam logic [OP_W-1:0] OP_MUL_IH   = 5'd8;
    localparam logic [OP_W-1:0] OP_ADD_IH   = 5'd9;
    localparam logic [OP_W-1:0] OP_ADD_I    = 5'd10;
    localparam logic [OP_W-1:0] OP_DIV_INIT = 5'd11;
    localparam logic [OP_W-1:0] OP_DIV_STEP = 5'd12;
    localparam logic [OP_W-1:0] OP_DIV_FIN  = 5'd13;
    localparam logic [OP_W-1:0] OP_MUL_DL   = 5'd14;
    localparam logic [OP_W-1:0] OP_ADD_DL   = 5'd15;
    localparam logic [OP_W-1:0] OP_MUL_DH   = 5'd16;
    localparam logic [OP_W-1:0] OP_ADD_DH   = 5'd17;
    localparam logic [OP_W-1:0] OP_CLAMP    = 5'd18;

    // Sequencer program.
    localparam int STEP_W = 5;
    localparam logic [STEP_W-1:0] STEP_LAST = 5'd16;
    localparam logic [STEP_W-1:0] DIV_LAST  = STEP_W'(QUO_W - 1);

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic signed [CFG_W-1:0] gain_prop;
        logic signed [CFG_W-1:0] gain_integ;
        logic signed [CFG_W-1:0] gain_deriv;
        logic signed [CFG_W-1:0] out_upper;
        logic signed [CFG_W-1:0] out_lower;
    } t_cfg;

    function automatic logic [OP_W-1:0] seq_op(input logic [STEP_W-1:0] step);
        logic [OP_W-1:0] op;
        unique case (step)
            5'd0:    op = OP_MUL_INC;
            5'd1:    op = OP_ACC_INT;
            5'd2:    op = OP_MUL_P;
            5'd3:    op = OP_ADD_P;
            5'd4:    op = OP_MUL_IL;
            5'd5:    op = OP_ADD_IL;
            5'd6:    op = OP_MUL_IH;
            5'd7:    op = OP_ADD_IH;
            5'd8:    op = OP_ADD_I;
            5'd9:    op = OP_DIV_INIT;
            5'd10:   op = OP_DIV_STEP;
            5'd11:   op = OP_DIV_FIN;
            5'd12:   op = OP_MUL_DL;
            5'd13:   op = OP_ADD_DL;
            5'd14:   op = OP_MUL_DH;
            5'd15:   op = OP_ADD_DH;
            5'd16:   op = OP_CLAMP;
            default: op = OP_NONE;
        endcase
        return op;
    endfunction

endpackage

/* design/pidt_cfg.sv */
// Configuration register file of the PID controller: gains and output limits.
module pidt_cfg import pidt_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_we,
    input  logic [CFG_IDX_W-1:0] i_idx,
    input  logic [CFG_W-1:0]     i_data,
    output t_cfg                 o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.gain_prop  <= '0;
            r_cfg.gain_integ <= '0;
            r_cfg.gain_deriv <= '0;
            r_cfg.out_upper  <= 16'sd256;
            r_cfg.out_lower  <= -16'sd256;
        end else if (i_we) begin
            unique case (i_idx)
                CFG_GAIN_PROP:  r_cfg.gain_prop  <= i_data;
                CFG_GAIN_INTEG: r_cfg.gain_integ <= i_data;
                CFG_GAIN_DERIV: r_cfg.gain_deriv <= i_data;
                CFG_OUT_UPPER:  r_cfg.out_upper  <= i_data;
                CFG_OUT_LOWER:  r_cfg.out_lower  <= i_data;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

/* design/pidt_dp.sv */
// Datapath of the PID controller: shared multiplier, integrator, serial divider, clamp.
module pidt_dp import pidt_pkg::*; (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  t_dp_cmd                    i_cmd,
    input  t_cfg                       i_cfg,
    input  logic                       i_kind,
    input  logic signed [SAMPLE_W-1:0] i_target,
    input  logic signed [SAMPLE_W-1:0] i_measured,
    input  logic [ELAPSED_W-1:0]       i_elapsed,
    output logic signed [DRIVE_W-1:0]  o_drive,
    output logic                       o_sat
);

    // Loop state.
    logic signed [SAMPLE_W-1:0] r_prev;
    logic signed [INTEG_W-1:0]  r_integ;

    // Working registers of one sample.
    logic signed [ERR_W-1:0]   r_err;
    logic signed [ESUM_W-1:0]  r_esum;
    logic signed [ERR_W-1:0]   r_diff;
    logic [ELAPSED_W-1:0]      r_dt;
    logic signed [PROD_W-1:0]  r_prod;
    logic signed [IACC_W-1:0]  r_iacc;
    logic signed [ACC_W-1:0]   r_acc;
    logic                      r_neg;
    logic [ELAPSED_W-1:0]      r_rem;
    logic [QUO_W-1:0]          r_quo;
    logic signed [SLOPE_W-1:0] r_slope;
    logic signed [DRIVE_W-1:0] r_drive;
    logic                      r_sat;
    logic signed [DRIVE_W-1:0] r_o_drive;
    logic                      r_o_sat;

    logic signed [ERR_W-1:0]   err_w;
    logic signed [ERR_W-1:0]   perr_w;
    logic signed [ERR_W-1:0]   diff_w;
    logic [ELAPSED_W-1:0]      dt_w;
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [PROD_W-1:0]  prod_w;
    logic signed [INC_W-1:0]   inc_w;
    logic signed [INTEG_W:0]   isum_w;
    logic [ELAPSED_W:0]        rem_sh;
    logic                      rem_ge;
    logic [ELAPSED_W:0]        rem_sub;
    logic signed [ERR_W-1:0]   abs_diff;
    logic [SLOPE_W-1:0]        quo_ext;
    logic signed [ACC_W-1:0]   prod_acc;
    logic signed [IACC_W-1:0]  prod_iacc;
    logic signed [IACC_W-1:0]  ishift;
    logic signed [ACC_W-1:0]   upper_w;
    logic signed [ACC_W-1:0]   lower_w;

    assign err_w  = ERR_W'(i_target) - ERR_W'(i_measured);
    assign perr_w = ERR_W'(i_target) - ERR_W'(r_prev);
    assign diff_w = ERR_W'(r_prev) - ERR_W'(i_measured);
    assign dt_w   = (i_elapsed == '0) ? ELAPSED_W'(1) : i_elapsed;

    // Operand selection for the single shared multiplier.
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (i_cmd.op)
            OP_MUL_INC: begin
                mul_a = MUL_A_W'(r_esum);
                mul_b = $signed({1'b0, r_dt});
            end
            OP_MUL_P: begin
                mul_a = MUL_A_W'(r_err);
                mul_b = MUL_B_W'(i_cfg.gain_prop);
            end
            OP_MUL_IL: begin
                mul_a = $signed({1'b0, r_integ[IPART_W-1:0]});
                mul_b = MUL_B_W'(i_cfg.gain_integ);
            end
            OP_MUL_IH: begin
                mul_a = MUL_A_W'($signed(r_integ[INTEG_W-1:IPART_W]));
                mul_b = MUL_B_W'(i_cfg.gain_integ);
            end
            OP_MUL_DL: begin
                mul_a = $signed({{(MUL_A_W-SLO_W){1'b0}}, r_slope[SLO_W-1:0]});
                mul_b = MUL_B_W'(i_cfg.gain_deriv);
            end
            OP_MUL_DH: begin
                mul_a = MUL_A_W'($signed(r_slope[SLOPE_W-1:SLO_W]));
                mul_b = MUL_B_W'(i_cfg.gain_deriv);
            end
            default: ;
        endcase
    end

    assign prod_w = mul_a * mul_b;

    // Integrator add; a mismatch of the two top bits means the sum left range.
    assign inc_w  = r_prod[INC_W-1:0];
    assign isum_w = (INTEG_W+1)'(r_integ) + (INTEG_W+1)'(inc_w);

    // One restoring division step on the magnitude of the measurement change.
    assign rem_sh  = {r_rem, r_quo[QUO_W-1]};
    assign rem_ge  = (rem_sh >= {1'b0, r_dt});
    assign rem_sub = rem_sh - {1'b0, r_dt};
    assign abs_diff = r_diff[ERR_W-1] ? -r_diff : r_diff;
    assign quo_ext  = {1'b0, r_quo};

    assign prod_acc  = ACC_W'(r_prod);
    assign prod_iacc = IACC_W'(r_prod);
    assign ishift    = r_iacc >>> INTEG_FRAC;
    assign upper_w   = ACC_W'(i_cfg.out_upper);
    assign lower_w   = ACC_W'(i_cfg.out_lower);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev  <= '0;
            r_integ <= '0;
        end else begin
            if (i_cmd.op == OP_LOAD) begin
                r_prev <= i_measured;
                if (i_kind) begin
                    r_integ <= '0;
                end
            end else if (i_cmd.op == OP_ACC_INT) begin
                if (isum_w[INTEG_W] != isum_w[INTEG_W-1]) begin
                    r_integ <= isum_w[INTEG_W] ? {1'b1, {(INTEG_W-1){1'b0}}}
                                               : {1'b0, {(INTEG_W-1){1'b1}}};
                end else begin
                    r_integ <= isum_w[INTEG_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= prod_w;
        case (i_cmd.op)
            OP_LOAD: begin
                r_err  <= err_w;
                r_esum <= ESUM_W'(err_w) + ESUM_W'(perr_w);
                r_diff <= diff_w;
                r_dt   <= dt_w;
                r_sat  <= 1'b0;
                if (i_kind) begin
                    r_drive <= '0;
                end
            end
            OP_ACC_INT: begin
                if (isum_w[INTEG_W] != isum_w[INTEG_W-1]) begin
                    r_sat <= 1'b1;
                end
            end
            OP_ADD_P:  r_acc  <= prod_acc;
            OP_ADD_IL: r_iacc <= prod_iacc;
            OP_ADD_IH: r_iacc <= r_iacc
                               + $signed({r_prod[IACC_W-IPART_W-1:0], {IPART_W{1'b0}}});
            OP_ADD_I:  r_acc  <= r_acc + ishift[ACC_W-1:0];
            OP_DIV_INIT: begin
                r_neg <= r_diff[ERR_W-1];
                r_rem <= '0;
                r_quo <= {abs_diff[SAMPLE_W-1:0], {ELAPSED_W{1'b0}}};
            end
            OP_DIV_STEP: begin
                r_rem <= rem_ge ? rem_sub[ELAPSED_W-1:0] : rem_sh[ELAPSED_W-1:0];
                r_quo <= {r_quo[QUO_W-2:0], rem_ge};
            end
            OP_DIV_FIN: r_slope <= r_neg ? -$signed(quo_ext) : $signed(quo_ext);
            OP_ADD_DL:  r_acc   <= r_acc + prod_acc;
            OP_ADD_DH:  r_acc   <= r_acc
                                 + $signed({prod_acc[ACC_W-SLO_W-1:0], {SLO_W{1'b0}}});
            OP_CLAMP: begin
                // When the limits are inverted, the upper limit wins above it and the lower limit below it.
                if (r_acc > upper_w) begin
                    r_drive <= i_cfg.out_upper;
                    r_sat   <= 1'b1;
                end else if (r_acc < lower_w) begin
                    r_drive <= i_cfg.out_lower;
                    r_sat   <= 1'b1;
                end else begin
                    r_drive <= r_acc[DRIVE_W-1:0];
                end
            end
            default: ;
        endcase
        if (i_cmd.out_load) begin
            r_o_drive <= r_drive;
            r_o_sat   <= r_sat;
        end
    end

    assign o_drive = r_o_drive;
    assign o_sat   = r_o_sat;

endmodule

/* design/pidt_ctrl.sv */
// Controller of the PID controller: handshakes and the sequencer of datapath operations.
module pidt_ctrl import pidt_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_s_valid,
    input  logic    i_kind,
    output logic    o_s_ready,
    output logic    o_m_valid,
    input  logic    i_m_ready,
    output t_dp_cmd o_cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0]        r_state, n_state;
    logic [STEP_W-1:0] r_step, n_step;
    logic [STEP_W-1:0] r_div_cnt, n_div_cnt;
    logic              r_m_valid;
    logic              accept;
    logic              out_load;
    logic [OP_W-1:0]   op;

    assign accept   = i_s_valid && (r_state == ST_IDLE);
    assign out_load = (r_state == ST_DONE) && (!r_m_valid || i_m_ready);

    always_comb begin
        op        = OP_NONE;
        n_state   = r_state;
        n_step    = r_step;
        n_div_cnt = r_div_cnt;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    op      = OP_LOAD;
                    n_step  = '0;
                    n_state = i_kind ? ST_DONE : ST_RUN;
                end
            end
            ST_RUN: begin
                op = seq_op(r_step);
                if (op == OP_DIV_STEP) begin
                    if (r_div_cnt == DIV_LAST) begin
                        n_div_cnt = '0;
                        n_step    = r_step + STEP_W'(1);
                    end else begin
                        n_div_cnt = r_div_cnt + STEP_W'(1);
                    end
                end else if (r_step == STEP_LAST) begin
                    n_step  = '0;
                    n_state = ST_DONE;
                end else begin
                    n_step = r_step + STEP_W'(1);
                end
            end
            ST_DONE: begin
                if (out_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_step    <= '0;
            r_div_cnt <= '0;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_step    <= n_step;
            r_div_cnt <= n_div_cnt;
            if (out_load) begin
                r_m_valid <= 1'b1;
            end else if (i_m_ready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    assign o_s_ready    = (r_state == ST_IDLE);
    assign o_m_valid    = r_m_valid;
    assign o_cmd.op       = op;
    assign o_cmd.out_load = out_load;

`ifndef SYNTHESIS
    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == ST_RUN || r_state == ST_DONE))
        else $error("accepted word did not start a run");
    a_div_cnt_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_div_cnt != '0) |-> (r_state == ST_RUN && op == OP_DIV_STEP))
        else $error("division counter active outside the division step");
    a_last_step_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RUN && r_step == STEP_LAST) |=> (r_state == ST_DONE))
        else $error("sequencer did not finish after its last step");
    a_load_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |=> r_m_valid)
        else $error("result load did not raise output valid");
`endif

endmodule

/* design/pid_controller_trapezoid.sv */
// Top level of the fixed-point PID controller with trapezoidal integral and clamped output.
//
//   Channel   Direction  Handshake                      Contents
//   s_axis    in         s_axis_tvalid / s_axis_tready  sample or restart word
//   m_axis    out        m_axis_tvalid / m_axis_tready  drive word and saturation flag
//   cfg       in         i_cfg_we (no back-pressure)    gain and limit registers
//
// A control word runs the sequencer from acceptance to a loaded result: its steps include six on
// the shared 25x17 multiplier, the bit-serial divider for a 32-bit quotient, and the output load;
// a restart word goes from acceptance straight to the output load.
// Reset is synchronous, active low; it clears the loop state and sets the register defaults.
// Input is accepted only while the sequencer is idle, so a new word waits until the last is loaded;
// a finished result waits in the output register while the next word is accepted and runs.
module pid_controller_trapezoid import pidt_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Sample channel.
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // target[15:0], measured[31:16], elapsed[47:32]
    input  logic                  s_axis_tuser,   // kind[0]: 0 control sample, 1 restart
    // Result channel.
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [DRIVE_W-1:0]    m_axis_tdata,   // drive[15:0]
    output logic                  m_axis_tuser,   // saturated[0]
    // Configuration write port.
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_W-1:0]      i_cfg_data
);

    t_cfg    cfg;
    t_dp_cmd cmd;

    logic signed [SAMPLE_W-1:0] target;
    logic signed [SAMPLE_W-1:0] measured;
    logic [ELAPSED_W-1:0]       elapsed;
    logic signed [DRIVE_W-1:0]  drive;

    // Unpack the sample word; the datapath samples these only in the acceptance cycle.
    assign target   = s_axis_tdata[SAMPLE_W-1:0];
    assign measured = s_axis_tdata[2*SAMPLE_W-1:SAMPLE_W];
    assign elapsed  = s_axis_tdata[IN_DATA_W-1:2*SAMPLE_W];

    pidt_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (i_cfg_we),
        .i_idx   (i_cfg_idx),
        .i_data  (i_cfg_data),
        .o_cfg   (cfg)
    );

    pidt_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (s_axis_tvalid),
        .i_kind    (s_axis_tuser),
        .o_s_ready (s_axis_tready),
        .o_m_valid (m_axis_tvalid),
        .i_m_ready (m_axis_tready),
        .o_cmd     (cmd)
    );

    pidt_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_cfg      (cfg),
        .i_kind     (s_axis_tuser),
        .i_target   (target),
        .i_measured (measured),
        .i_elapsed  (elapsed),
        .o_drive    (drive),
        .o_sat      (m_axis_tuser)
    );

    assign m_axis_tdata = drive;

endmodule
